>>> rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, reset included
`define HCBP_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");

// property checked only while reset is released
`define HCBP_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

`endif

>>> rtl/hcbp_pkg.sv
// types and constants of the huffman code bit packer
package hcbp_pkg;

    localparam int BYTE_W      = 8;
    localparam int SYMBOL_W    = 8;
    localparam int CODE_IN_W   = 16;
    localparam int LEN_W       = 5;
    localparam int PEND_W      = 7;
    localparam int PCNT_W      = 3;
    localparam int STREAM_W    = 24;
    localparam int RESULTS_MAX = 2;
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = 2;
    localparam int OUTQ_CNT_W  = 3;
    localparam int PUSH_W      = 2;

    typedef enum logic [1:0] {
        OP_ENCODE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [PUSH_W-1:0] cnt;
        t_result           e0;
        t_result           e1;
    } t_push;

endpackage

>>> rtl/hcbp_out_q.sv
// small result queue: up to two pushes and one pop per cycle
module hcbp_out_q (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hcbp_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_room,
    output logic            o_valid,
    output hcbp_pkg::t_result o_head
);

    hcbp_pkg::t_result                      r_q [hcbp_pkg::OUTQ_DEPTH];
    logic [hcbp_pkg::OUTQ_PTR_W-1:0]        r_wr;
    logic [hcbp_pkg::OUTQ_PTR_W-1:0]        r_rd;
    logic [hcbp_pkg::OUTQ_CNT_W-1:0]        r_count;
    logic                                   pop_ok;

    assign o_valid = (r_count != '0);
    assign o_head  = r_q[r_rd];
    assign o_room  = (r_count <= hcbp_pkg::OUTQ_CNT_W'(hcbp_pkg::OUTQ_DEPTH
                                                       - hcbp_pkg::RESULTS_MAX));
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != '0) begin
            r_q[r_wr] <= i_push.e0;
        end
        if (i_push.cnt == hcbp_pkg::PUSH_W'(2)) begin
            r_q[hcbp_pkg::OUTQ_PTR_W'(r_wr + 1'b1)] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= hcbp_pkg::OUTQ_PTR_W'(r_wr + i_push.cnt);
            r_rd    <= hcbp_pkg::OUTQ_PTR_W'(r_rd + pop_ok);
            r_count <= hcbp_pkg::OUTQ_CNT_W'(r_count + i_push.cnt - pop_ok);
        end
    end

endmodule

>>> rtl/huffman_code_bit_packer.sv
// static-table huffman encoder that packs code bits into bytes
// path: table read at the accepting edge, packing in stage 1, then the result queue offers the byte
// throughput: one item per cycle while the result queue has room, one byte per cycle out;
// a registered table read (read at accept, pack in stage 1) and a 4-entry result queue set the pace
// items that emit two bytes in a row drain at one byte per cycle and back up the input
// reset clears pending bits, pipeline and queue; the code table is not cleared
module huffman_code_bit_packer #(
    parameter int SYMBOL_COUNT    = 256,
    parameter int MAX_CODE_LENGTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_operation,
    input  logic [hcbp_pkg::SYMBOL_W-1:0]    i_symbol,
    input  logic [hcbp_pkg::CODE_IN_W-1:0]   i_code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]       i_code_length,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]      o_packed_byte,
    output logic                             o_last_of_run
);

    localparam int IDX_W  = $clog2(SYMBOL_COUNT);
    localparam int CODE_W = MAX_CODE_LENGTH;
    localparam int ENT_W  = CODE_W + hcbp_pkg::LEN_W;

    // code table: {length, code} per symbol, at most one write and one read per cycle
    logic [ENT_W-1:0]               r_table [SYMBOL_COUNT];
    logic [ENT_W-1:0]               r_rd_data;

    // stage 1: item waiting on its table read
    logic                           r_s1_valid;
    hcbp_pkg::t_op                  r_s1_op;
    logic                           r_s1_hit;

    // unfinished byte
    logic [hcbp_pkg::PEND_W-1:0]    r_pend;
    logic [hcbp_pkg::PCNT_W-1:0]    r_cnt;
    logic [hcbp_pkg::PEND_W-1:0]    n_pend;
    logic [hcbp_pkg::PCNT_W-1:0]    n_cnt;

    logic                           in_acc;
    hcbp_pkg::t_op                  in_op;
    logic                           in_hit;
    logic [IDX_W-1:0]               in_idx;
    logic [hcbp_pkg::LEN_W-1:0]     load_len;
    logic [CODE_W-1:0]              load_mask;
    logic [CODE_W-1:0]              load_code;

    logic [hcbp_pkg::LEN_W-1:0]     clen_raw;
    logic [hcbp_pkg::LEN_W-1:0]     clen;
    logic [CODE_W-1:0]              code;
    logic [CODE_W-1:0]              aligned;
    logic [CODE_W-1:0]              rev;
    logic [hcbp_pkg::STREAM_W-1:0]  stream;
    logic [hcbp_pkg::STREAM_W-1:0]  shifted;
    logic [hcbp_pkg::LEN_W-1:0]     total;
    logic [1:0]                     nbytes;

    logic                           fire;
    logic                           q_room;
    hcbp_pkg::t_push                push;
    hcbp_pkg::t_result              head;

    // input side
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_op      = hcbp_pkg::t_op'(i_operation);
    assign in_hit     = (int'(i_symbol) < SYMBOL_COUNT);
    assign in_idx     = i_symbol[IDX_W-1:0];
    assign fire       = r_s1_valid && q_room;
    assign o_in_ready = !r_s1_valid || q_room;

    // loads saturate the length and drop code bits above it
    always_comb begin
        load_len = (i_code_length > hcbp_pkg::LEN_W'(MAX_CODE_LENGTH))
                 ? hcbp_pkg::LEN_W'(MAX_CODE_LENGTH) : i_code_length;
        for (int i = 0; i < CODE_W; i++) begin
            load_mask[i] = (hcbp_pkg::LEN_W'(i) < load_len);
        end
        load_code = i_code_bits[CODE_W-1:0] & load_mask;
    end

    // table write on load, table read on every accepted transaction;
    // a load and a later encode of the same entry never share an edge,
    // so the read always sees the latest write
    always_ff @(posedge i_clk) begin
        if (in_acc && in_hit && (in_op == hcbp_pkg::OP_LOAD)) begin
            r_table[in_idx] <= {load_len, load_code};
        end
        if (in_acc) begin
            r_rd_data <= r_table[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op  <= in_op;
            r_s1_hit <= in_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // bit append: reverse the code so its msb lands at the lowest free position
    always_comb begin
        clen_raw = r_rd_data[ENT_W-1:CODE_W];
        code     = r_rd_data[CODE_W-1:0];
        if (!r_s1_hit) begin
            clen = '0;
        end else if (clen_raw > hcbp_pkg::LEN_W'(MAX_CODE_LENGTH)) begin
            clen = hcbp_pkg::LEN_W'(MAX_CODE_LENGTH);
        end else begin
            clen = clen_raw;
        end
        aligned = code << (hcbp_pkg::LEN_W'(CODE_W) - clen);
        for (int i = 0; i < CODE_W; i++) begin
            rev[i] = aligned[CODE_W-1-i];
        end
        stream  = hcbp_pkg::STREAM_W'(r_pend)
                | (hcbp_pkg::STREAM_W'(rev) << r_cnt);
        total   = hcbp_pkg::LEN_W'(r_cnt) + clen;
        nbytes  = total[4:3];
        shifted = stream >> {nbytes, 3'b000};
    end

    // results and next pending state of the item in stage 1
    always_comb begin
        push.cnt     = '0;
        push.e0.data = stream[hcbp_pkg::BYTE_W-1:0];
        push.e0.last = 1'b1;
        push.e1.data = stream[2*hcbp_pkg::BYTE_W-1:hcbp_pkg::BYTE_W];
        push.e1.last = 1'b1;
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        unique case (r_s1_op)
            hcbp_pkg::OP_ENCODE: begin
                push.cnt     = nbytes;
                push.e0.last = (nbytes == 2'd1);
                n_pend       = shifted[hcbp_pkg::PEND_W-1:0];
                n_cnt        = total[hcbp_pkg::PCNT_W-1:0];
            end
            hcbp_pkg::OP_FLUSH: begin
                if (r_cnt != '0) begin
                    push.cnt     = hcbp_pkg::PUSH_W'(1);
                    push.e0.data = {1'b0, r_pend};
                    n_pend       = '0;
                    n_cnt        = '0;
                end
            end
            default: begin
            end
        endcase
        if (!fire) begin
            push.cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else if (fire) begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

    // output queue decouples byte delivery from the packing stage
    hcbp_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_out_ready),
        .o_room  (q_room),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_packed_byte = head.data;
    assign o_last_of_run = head.last;

endmodule

>>> rtl/hcbp_checker.sv
// port-level checks of the huffman code bit packer and their bind
`include "assert_macros.svh"

module hcbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_packed_byte,
    input logic       o_last_of_run
);

    logic       out_wait;
    logic       out_take;
    logic [8:0] out_word;

    assign out_wait = o_out_valid && !i_out_ready;
    assign out_take = o_out_valid && i_out_ready;
    assign out_word = {o_last_of_run, o_packed_byte};

    // a waiting byte holds until taken
    `HCBP_ASSERT_RST(a_out_hold, i_clk, i_rst_n, out_wait |=> (o_out_valid && $stable(out_word)))

    // reset empties the result queue
    `HCBP_ASSERT(a_rst_empty, i_clk, (!i_rst_n) |=> (!o_out_valid))

    // the input stalls only behind undelivered bytes
    `HCBP_ASSERT_RST(a_stall_cause, i_clk, i_rst_n, (!o_in_ready) |-> o_out_valid)

    // the second byte of a pair is queued with the first
    `HCBP_ASSERT_RST(a_pair_whole, i_clk, i_rst_n, (out_take && !o_last_of_run) |=> o_out_valid)

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

>>> sim/huffman_code_bit_packer_tb.sv
// self-checking testbench for the static-table huffman code bit packer
`timescale 1ns / 1ps

module huffman_code_bit_packer_tb;

    // operation code the block leaves unused; it must be swallowed silently
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_CODE_LEN   = 16;
    localparam int SYMBOLS        = 256;
    localparam int RANDOM_ITEMS   = 850;
    localparam int IDLE_PCT       = 38;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int DRAIN_CYCLES   = 8;

    // one row of stimulus; typed rows carry their expected bytes directly
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  sym;
        logic [15:0] bits;
        logic [4:0]  len;
        logic        typed;
        logic [1:0]  n;
        logic [7:0]  b0;
        logic [7:0]  b1;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_operation;
    logic [hcbp_pkg::SYMBOL_W-1:0]  i_symbol;
    logic [hcbp_pkg::CODE_IN_W-1:0] i_code_bits;
    logic [hcbp_pkg::LEN_W-1:0]     i_code_length;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [hcbp_pkg::BYTE_W-1:0]    o_packed_byte;
    logic        o_last_of_run;

    // predictor state: its own copy of the code table and the unfinished byte
    logic [15:0] code_word [SYMBOLS];
    logic [4:0]  code_size [SYMBOLS];
    logic        sym_loaded [SYMBOLS];
    logic [6:0]  pend_bits;
    logic [2:0]  pend_cnt;

    hcbp_pkg::t_result expected_bytes [$];
    t_row    directed_rows [$];
    int      loaded_syms [$];

    int idle_pct;
    int stall_pct;
    int cycle_cnt;
    int mismatch_cnt;
    int items_sent;
    int bytes_checked;
    int bytes_predicted;

    huffman_code_bit_packer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packed_byte (o_packed_byte),
        .o_last_of_run (o_last_of_run)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_row mk_row(input logic [1:0] op, input logic [7:0] sym,
                                    input logic [15:0] bits, input logic [4:0] len,
                                    input logic typed, input logic [1:0] n,
                                    input logic [7:0] b0, input logic [7:0] b1);
        t_row r;
        r.op    = op;
        r.sym   = sym;
        r.bits  = bits;
        r.len   = len;
        r.typed = typed;
        r.n     = n;
        r.b0    = b0;
        r.b1    = b1;
        return r;
    endfunction

    // works out the bytes one accepted transaction produces and advances the state
    task automatic pack_code_bits(input logic [1:0] op, input logic [7:0] sym,
                                  input logic [15:0] bits, input logic [4:0] len,
                                  output int n, output logic [7:0] b0,
                                  output logic [7:0] b1);
        int          l;
        int          cnt;
        int          i;
        logic [7:0]  acc;
        logic [31:0] masked;
        n  = 0;
        b0 = 8'h00;
        b1 = 8'h00;
        case (op)
            hcbp_pkg::OP_LOAD: begin
                // lengths above the maximum saturate, bits above the length drop
                l = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
                masked = {16'd0, bits} & ((32'd1 << l) - 32'd1);
                code_word[sym] = masked[15:0];
                code_size[sym] = l[4:0];
            end
            hcbp_pkg::OP_ENCODE: begin
                acc = {1'b0, pend_bits};
                cnt = int'(pend_cnt);
                // msb of the code goes first, filling the byte from bit 0 up
                for (i = int'(code_size[sym]) - 1; i >= 0; i--) begin
                    acc[cnt] = code_word[sym][i];
                    cnt++;
                    if (cnt == 8) begin
                        if (n == 0) b0 = acc;
                        else b1 = acc;
                        n++;
                        acc = 8'h00;
                        cnt = 0;
                    end
                end
                pend_bits = acc[6:0];
                pend_cnt  = cnt[2:0];
            end
            hcbp_pkg::OP_FLUSH: begin
                if (pend_cnt != 3'd0) begin
                    b0 = {1'b0, pend_bits};
                    n  = 1;
                    pend_bits = 7'd0;
                    pend_cnt  = 3'd0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_bytes(input int n, input logic [7:0] b0, input logic [7:0] b1);
        hcbp_pkg::t_result e;
        if (n >= 1) begin
            e.data = b0;
            e.last = (n == 1);
            expected_bytes.push_back(e);
        end
        if (n == 2) begin
            e.data = b1;
            e.last = 1'b1;
            expected_bytes.push_back(e);
        end
        bytes_predicted += n;
    endtask

    // offers one transaction, with a random gap first, and predicts it on acceptance
    task automatic send_item(input t_row r);
        int         n;
        logic [7:0] b0;
        logic [7:0] b1;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= r.op;
        i_symbol      <= r.sym;
        i_code_bits   <= r.bits;
        i_code_length <= r.len;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // accepted at this edge; valid is left alone so the next item can follow
        items_sent++;
        pack_code_bits(r.op, r.sym, r.bits, r.len, n, b0, b1);
        if (r.typed) queue_bytes(int'(r.n), r.b0, r.b1);
        else queue_bytes(n, b0, b1);
        if (r.op == hcbp_pkg::OP_LOAD && !sym_loaded[r.sym]) begin
            sym_loaded[r.sym] = 1'b1;
            loaded_syms.push_back(int'(r.sym));
        end
    endtask

    // output side: random back-pressure and in-order comparison of every byte
    always @(posedge i_clk) begin : out_check
        hcbp_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %h last %b", $time,
                         o_packed_byte, o_last_of_run);
                mismatch_cnt++;
            end else begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (o_packed_byte !== want.data) begin
                    $display("%0t: packed_byte expected %h actual %h", $time,
                             want.data, o_packed_byte);
                    mismatch_cnt++;
                end
                if (o_last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %b actual %b", $time,
                             want.last, o_last_of_run);
                    mismatch_cnt++;
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("run stopped after %0d cycles, %0d bytes still awaited",
                     cycle_cnt, expected_bytes.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int         k;
        int         r;
        int         l;
        logic [1:0] op;
        logic [7:0] sym;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_operation   <= hcbp_pkg::OP_ENCODE;
        i_symbol      <= '0;
        i_code_bits   <= '0;
        i_code_length <= '0;
        i_out_ready   <= 1'b0;
        idle_pct      = IDLE_PCT;
        stall_pct     = IDLE_PCT;
        cycle_cnt     = 0;
        mismatch_cnt  = 0;
        items_sent    = 0;
        bytes_checked = 0;
        bytes_predicted = 0;
        pend_bits     = 7'd0;
        pend_cnt      = 3'd0;
        for (k = 0; k < SYMBOLS; k++) begin
            code_word[k]  = 16'd0;
            code_size[k]  = 5'd0;
            sym_loaded[k] = 1'b0;
        end

        // directed part: typed rows are plain enough to read off by hand
        // flush with nothing pending and the unused operation give nothing
        directed_rows.push_back(mk_row(hcbp_pkg::OP_FLUSH, 8'd0, 16'h0000, 5'd0,
                                       1'b1, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(OP_UNUSED, 8'd255, 16'hFFFF, 5'd31,
                                       1'b1, 2'd0, 8'h00, 8'h00));
        // a full byte of ones at the lowest index
        directed_rows.push_back(mk_row(hcbp_pkg::OP_LOAD, 8'd0, 16'hFFFF, 5'd8,
                                       1'b1, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd0, 16'h0000, 5'd0,
                                       1'b1, 2'd1, 8'hFF, 8'h00));
        // length far above the maximum saturates to 16 at the top index
        directed_rows.push_back(mk_row(hcbp_pkg::OP_LOAD, 8'd255, 16'hFFFF, 5'd31,
                                       1'b1, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd255, 16'h0000, 5'd0,
                                       1'b1, 2'd2, 8'hFF, 8'hFF));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_LOAD, 8'd1, 16'h0000, 5'd16,
                                       1'b1, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd1, 16'h0000, 5'd0,
                                       1'b1, 2'd2, 8'h00, 8'h00));
        // zero-length code appends nothing
        directed_rows.push_back(mk_row(hcbp_pkg::OP_LOAD, 8'd2, 16'hFFFF, 5'd0,
                                       1'b1, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd2, 16'h0000, 5'd0,
                                       1'b1, 2'd0, 8'h00, 8'h00));
        // 3-bit code 101 stays pending, then the flush pads it
        directed_rows.push_back(mk_row(hcbp_pkg::OP_LOAD, 8'd3, 16'h0005, 5'd3,
                                       1'b1, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd3, 16'h0000, 5'd0,
                                       1'b1, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_FLUSH, 8'd0, 16'h0000, 5'd0,
                                       1'b1, 2'd1, 8'h05, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_FLUSH, 8'd0, 16'h0000, 5'd0,
                                       1'b1, 2'd0, 8'h00, 8'h00));
        // mixed lengths across byte boundaries, checked by the predictor
        directed_rows.push_back(mk_row(hcbp_pkg::OP_LOAD, 8'd4, 16'hABCD, 5'd20,
                                       1'b0, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_LOAD, 8'd5, 16'hFFFF, 5'd4,
                                       1'b0, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_LOAD, 8'd6, 16'h5555, 5'd16,
                                       1'b0, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_LOAD, 8'd7, 16'h002A, 5'd7,
                                       1'b0, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd3, 16'h0000, 5'd0,
                                       1'b0, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd4, 16'h0000, 5'd0,
                                       1'b0, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd5, 16'h0000, 5'd0,
                                       1'b0, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd6, 16'h0000, 5'd0,
                                       1'b0, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd7, 16'h0000, 5'd0,
                                       1'b0, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_ENCODE, 8'd2, 16'h0000, 5'd0,
                                       1'b0, 2'd0, 8'h00, 8'h00));
        directed_rows.push_back(mk_row(hcbp_pkg::OP_FLUSH, 8'd0, 16'h0000, 5'd0,
                                       1'b0, 2'd0, 8'h00, 8'h00));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) send_item(directed_rows[k]);

        // random part: mostly encodes of loaded symbols, with table rewrites,
        // flushes at any point and the odd unused operation
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            // a long stretch with both sides running flat out
            idle_pct  = (k >= 300 && k < 450) ? 0 : IDLE_PCT;
            stall_pct = idle_pct;
            r   = $urandom_range(0, 99);
            sym = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
            op  = hcbp_pkg::OP_ENCODE;
            if (r >= 60 && r < 78) begin
                op  = hcbp_pkg::OP_LOAD;
                sym = 8'($urandom_range(0, SYMBOLS - 1));
            end else if (r >= 78 && r < 92) begin
                op = hcbp_pkg::OP_FLUSH;
            end else if (r >= 92 && r < 95) begin
                op  = OP_UNUSED;
                sym = 8'($urandom_range(0, SYMBOLS - 1));
            end
            // code lengths mostly legal, some zero, some past the maximum
            r = $urandom_range(0, 99);
            if (r < 6) l = $urandom_range(MAX_CODE_LEN + 1, 31);
            else if (r < 12) l = 0;
            else l = $urandom_range(1, MAX_CODE_LEN);
            send_item(mk_row(op, sym, 16'($urandom_range(0, 65535)), l[4:0],
                             1'b0, 2'd0, 8'h00, 8'h00));
        end
        i_in_valid <= 1'b0;

        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d transactions, %0d table entries in use", items_sent,
                 loaded_syms.size());
        $display("checked %0d packed bytes out of %0d predicted, %0d mismatches",
                 bytes_checked, bytes_predicted, mismatch_cnt);
        if (mismatch_cnt == 0 && expected_bytes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
